### design/pri_pkg.sv
// Package for the polynomial resampling interpolator.
// Holds mode codes, default widths and the tap weight table.
// No dependencies.
package pri_pkg;

  localparam int SAMPLE_W_DEF = 24;
  localparam int PHASE_W_DEF  = 16;
  localparam int MODE_W       = 3;
  localparam int NUM_TAPS     = 6;
  localparam int NUM_COEF     = 6;
  // weights are scaled by 2^24, below GUARD bits of the sample LSB
  localparam int WFRAC        = 24;
  localparam int GUARD        = 8;
  localparam int WW           = 27;

  typedef enum logic [MODE_W-1:0] {
    MODE_HOLD     = 3'd0,
    MODE_LINEAR   = 3'd1,
    MODE_CUBIC    = 3'd2,
    MODE_OSC      = 3'd3,
    MODE_BSPLINE4 = 3'd4,
    MODE_BSPLINE6 = 3'd5,
    MODE_OPT4     = 3'd6,
    MODE_OPT6     = 3'd7
  } interp_mode_e;

  // modes evaluated around the midpoint of the interval
  localparam logic [7:0] ZFORM = 8'b1100_1000;

  typedef logic signed [WW-1:0] weight_t;

  // [mode][coefficient][tap m2,m1,0,p1,p2,p3]
  localparam weight_t WTAB [8][NUM_COEF][NUM_TAPS] = '{
    '{ '{27'sd0, 27'sd0, 27'sd16777216, 27'sd0, 27'sd0, 27'sd0},
       '{27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0},
       '{27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0},
       '{27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0},
       '{27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0},
       '{27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0} },
    '{ '{27'sd0, 27'sd0, 27'sd16777216, 27'sd0, 27'sd0, 27'sd0},
       '{27'sd0, 27'sd0, -27'sd16777216, 27'sd16777216, 27'sd0, 27'sd0},
       '{27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0},
       '{27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0},
       '{27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0},
       '{27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0} },
    '{ '{27'sd0, 27'sd0, 27'sd16777216, 27'sd0, 27'sd0, 27'sd0},
       '{27'sd0, -27'sd8388608, 27'sd0, 27'sd8388608, 27'sd0, 27'sd0},
       '{27'sd0, 27'sd16777216, -27'sd41943040, 27'sd33554432, -27'sd8388608, 27'sd0},
       '{27'sd0, -27'sd8388608, 27'sd25165824, -27'sd25165824, 27'sd8388608, 27'sd0},
       '{27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0},
       '{27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0} },
    '{ '{27'sd0, -27'sd1048576, 27'sd9437184, 27'sd9437184, -27'sd1048576, 27'sd0},
       '{27'sd0, 27'sd3145728, -27'sd26214400, 27'sd26214400, -27'sd3145728, 27'sd0},
       '{27'sd0, 27'sd4194304, -27'sd4194304, -27'sd4194304, 27'sd4194304, 27'sd0},
       '{27'sd0, -27'sd16777216, 27'sd50331648, -27'sd50331648, 27'sd16777216, 27'sd0},
       '{27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0},
       '{27'sd0, 27'sd16777216, -27'sd50331648, 27'sd50331648, -27'sd16777216, 27'sd0} },
    '{ '{27'sd0, 27'sd2796203, 27'sd11184811, 27'sd2796203, 27'sd0, 27'sd0},
       '{27'sd0, -27'sd8388608, 27'sd0, 27'sd8388608, 27'sd0, 27'sd0},
       '{27'sd0, 27'sd8388608, -27'sd16777216, 27'sd8388608, 27'sd0, 27'sd0},
       '{27'sd0, -27'sd2796203, 27'sd8388608, -27'sd8388608, 27'sd2796203, 27'sd0},
       '{27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0},
       '{27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0} },
    '{ '{27'sd139810, 27'sd3635063, 27'sd9227469, 27'sd3635063, 27'sd139810, 27'sd0},
       '{-27'sd699051, -27'sd6990507, 27'sd0, 27'sd6990507, 27'sd699051, 27'sd0},
       '{27'sd1398101, 27'sd2796203, -27'sd8388608, 27'sd2796203, 27'sd1398101, 27'sd0},
       '{-27'sd1398101, 27'sd2796203, 27'sd0, -27'sd2796203, 27'sd1398101, 27'sd0},
       '{27'sd699051, -27'sd2796203, 27'sd4194304, -27'sd2796203, 27'sd699051, 27'sd0},
       '{-27'sd139810, 27'sd699051, -27'sd1398101, 27'sd1398101, -27'sd699051,
         27'sd139810} },
    '{ '{27'sd0, 27'sd730509, 27'sd7658114, 27'sd7658114, 27'sd730509, 27'sd0},
       '{27'sd0, -27'sd2967321, -27'sd7924999, 27'sd7924999, 27'sd2967321, 27'sd0},
       '{27'sd0, 27'sd4256702, -27'sd4255957, -27'sd4255957, 27'sd4256702, 27'sd0},
       '{27'sd0, -27'sd2005375, 27'sd6361432, -27'sd6361432, 27'sd2005375, 27'sd0},
       '{27'sd0, -27'sd719599, 27'sd713395, 27'sd713395, -27'sd719599, 27'sd0},
       '{27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0, 27'sd0} },
    '{ '{27'sd39394, 27'sd1552194, 27'sd6797020, 27'sd6797020, 27'sd1552194, 27'sd39394},
       '{-27'sd219663, -27'sd3641206, -27'sd4755134, 27'sd4755134, 27'sd3641206,
         27'sd219663},
       '{27'sd494260, 27'sd2715870, -27'sd3210114, -27'sd3210114, 27'sd2715870,
         27'sd494260},
       '{-27'sd570303, 27'sd25929, 27'sd2763480, -27'sd2763480, -27'sd25929, 27'sd570303},
       '{27'sd313189, -27'sd958472, 27'sd645218, 27'sd645218, -27'sd958472, 27'sd313189},
       '{-27'sd25530, 27'sd302462, -27'sd724432, 27'sd724432, -27'sd302462, 27'sd25530} }
  };

endpackage

### design/pri_coef.sv
// Coefficient stages: weight times tap products, then sum, round, clamp.
// Two register stages. Depends on pri_pkg.
module pri_coef #(
  parameter int SW = pri_pkg::SAMPLE_W_DEF,
  parameter int CW = 62 - pri_pkg::PHASE_W_DEF
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [pri_pkg::MODE_W-1:0]    mode_i,
  input  logic signed [SW-1:0]          taps_i [pri_pkg::NUM_TAPS],
  output logic signed [CW-1:0]          coef_o [pri_pkg::NUM_COEF]
);
  import pri_pkg::*;

  localparam int PW_  = SW + WW;
  localparam int AW   = PW_ + 3;
  localparam int SH   = WFRAC - GUARD;
  localparam int LW   = (AW + 1 > CW + 1) ? AW + 1 : CW + 1;
  localparam logic signed [LW-1:0] LIM = LW'((64'sd1 <<< (CW - 1)) - 64'sd1);

  logic signed [PW_-1:0] prod_q [NUM_COEF][NUM_TAPS];
  logic signed [CW-1:0]  coef_q [NUM_COEF];
  logic signed [CW-1:0]  coef_d [NUM_COEF];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NUM_COEF; k++) begin
        for (int t = 0; t < NUM_TAPS; t++) begin
          prod_q[k][t] <= PW_'(WTAB[mode_i][k][t] * taps_i[t]);
        end
      end
      coef_q <= coef_d;
    end
  end

  always_comb begin
    logic signed [AW-1:0] acc;
    logic signed [LW-1:0] r;
    for (int k = 0; k < NUM_COEF; k++) begin
      acc = '0;
      for (int t = 0; t < NUM_TAPS; t++) begin
        acc = acc + AW'(prod_q[k][t]);
      end
      r = LW'((acc + (AW'(1) <<< (SH - 1))) >>> SH);
      if (r > LIM)       coef_d[k] = CW'(LIM);
      else if (r < -LIM) coef_d[k] = CW'(-LIM);
      else               coef_d[k] = CW'(r);
    end
  end

  assign coef_o = coef_q;

endmodule

### design/pri_horner_step.sv
// One Horner step: multiply stage, then round, add coefficient K, clamp.
// Carries the phase and coefficient set along. Depends on pri_pkg.
module pri_horner_step #(
  parameter int K  = 4,
  parameter int CW = 62 - pri_pkg::PHASE_W_DEF,
  parameter int PW = pri_pkg::PHASE_W_DEF
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] h_i,
  input  logic signed [PW:0]   v_i,
  input  logic signed [CW-1:0] c_i [pri_pkg::NUM_COEF],
  output logic signed [CW-1:0] h_o,
  output logic signed [PW:0]   v_o,
  output logic signed [CW-1:0] c_o [pri_pkg::NUM_COEF]
);
  import pri_pkg::*;

  localparam int MW = CW + PW + 1;
  localparam int SW2 = CW + 2;
  localparam logic signed [SW2-1:0] LIM = SW2'((64'sd1 <<< (CW - 1)) - 64'sd1);

  logic signed [MW-1:0] prod_q;
  logic signed [CW-1:0] ck_q;
  logic signed [PW:0]   v1_q, v2_q;
  logic signed [CW-1:0] c1_q [NUM_COEF];
  logic signed [CW-1:0] c2_q [NUM_COEF];
  logic signed [CW-1:0] h_q, h_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= MW'(h_i * v_i);
      ck_q   <= c_i[K];
      v1_q   <= v_i;
      c1_q   <= c_i;
      h_q    <= h_d;
      v2_q   <= v1_q;
      c2_q   <= c1_q;
    end
  end

  always_comb begin
    logic signed [SW2-1:0] s;
    s = SW2'((prod_q + (MW'(1) <<< (PW - 1))) >>> PW) + SW2'(ck_q);
    if (s > LIM)       h_d = CW'(LIM);
    else if (s < -LIM) h_d = CW'(-LIM);
    else               h_d = CW'(s);
  end

  assign h_o = h_q;
  assign v_o = v2_q;
  assign c_o = c2_q;

endmodule

### design/polynomial_resampling_interpolator.sv
// Polynomial resampling interpolator, bank of eight kernels of up to 6 points.
// Pipeline: 2 coefficient stages, 5 Horner steps of 2, 1 output.
// Throughput: one transaction per cycle while the pipeline advances; the whole
// pipeline advances when the output register is empty or taken.
// Reset: asynchronous active low, clears valid bits and sets mode to linear.
module polynomial_resampling_interpolator #(
  parameter int SAMPLE_WIDTH = pri_pkg::SAMPLE_W_DEF,
  parameter int PHASE_WIDTH  = pri_pkg::PHASE_W_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pri_pkg::MODE_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [PHASE_WIDTH-1:0]         frac_phase_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_m2_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_m1_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_0_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_p1_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_p2_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_p3_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] interp_out_o
);
  import pri_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int PW    = PHASE_WIDTH;
  localparam int CW    = 62 - PW;
  localparam int NSTEP = NUM_COEF - 1;
  localparam int DEPTH = 2 + 2 * NSTEP + 1;
  localparam int RW    = (CW + 1 > SW + 1) ? CW + 1 : SW + 1;
  localparam logic signed [RW-1:0] SMAX = RW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] SMIN = -SMAX - RW'(1);

  logic [MODE_W-1:0]  mode_q;
  logic [DEPTH-1:0]   vld_q;
  logic               en;
  logic signed [SW-1:0] taps [NUM_TAPS];
  logic signed [PW:0]   v_d, v0_q, v1_q;
  logic signed [CW-1:0] coef [NUM_COEF];
  logic signed [CW-1:0] h_s [NSTEP+1];
  logic signed [PW:0]   v_s [NSTEP+1];
  logic signed [CW-1:0] c_s [NSTEP+1][NUM_COEF];
  logic signed [SW-1:0] out_q, out_d;

  assign en         = !vld_q[DEPTH-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LINEAR;
      vld_q  <= '0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (en)       vld_q  <= {vld_q[DEPTH-2:0], in_valid_i};
    end
  end

  assign taps = '{sample_m2_i, sample_m1_i, sample_0_i, sample_p1_i, sample_p2_i,
                  sample_p3_i};

  always_comb begin
    v_d = $signed({1'b0, frac_phase_i});
    if (ZFORM[mode_q]) v_d = v_d - ((PW+1)'(1) <<< (PW - 1));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      v0_q  <= v_d;
      v1_q  <= v0_q;
      out_q <= out_d;
    end
  end

  pri_coef #(.SW(SW), .CW(CW)) u_coef (
    .clk_i  (clk_i),
    .en_i   (en),
    .mode_i (mode_q),
    .taps_i (taps),
    .coef_o (coef)
  );

  assign h_s[0] = coef[NUM_COEF-1];
  assign v_s[0] = v1_q;
  assign c_s[0] = coef;

  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    pri_horner_step #(.K(NSTEP - 1 - j), .CW(CW), .PW(PW)) u_step (
      .clk_i (clk_i),
      .en_i  (en),
      .h_i   (h_s[j]),
      .v_i   (v_s[j]),
      .c_i   (c_s[j]),
      .h_o   (h_s[j+1]),
      .v_o   (v_s[j+1]),
      .c_o   (c_s[j+1])
    );
  end

  // drop guard bits with rounding, saturate to sample range
  always_comb begin
    logic signed [RW-1:0] y;
    y = RW'((RW'(h_s[NSTEP]) + (RW'(1) <<< (GUARD - 1))) >>> GUARD);
    if (y > SMAX)      out_d = SW'(SMAX);
    else if (y < SMIN) out_d = SW'(SMIN);
    else               out_d = SW'(y);
  end

  assign out_valid_o  = vld_q[DEPTH-1];
  assign interp_out_o = out_q;

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> mode_q == $past(cfg_wdata_i))
    else $error("mode register not updated by write");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during stall");

  a_accept_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && in_valid_i) |=> vld_q[0])
    else $error("accepted transaction not captured");

endmodule

### test/tb_top.sv
// Testbench for polynomial_resampling_interpolator: random and directed items, eight modes.
// A scoreboard class predicts each result in fixed point; depends on pri_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import pri_pkg::*;

  localparam int SW = 24;
  localparam int PW = 16;
  localparam longint COEF_LIM = (64'sd1 <<< 45) - 1;
  localparam longint SMAX = (64'sd1 <<< (SW - 1)) - 1;

  typedef struct {
    logic [PW-1:0]        phase;
    logic signed [SW-1:0] tap [6];
  } interp_item_t;

  class interp_scoreboard;
    int weight [8][6][6];
    interp_mode_e mode;
    logic signed [SW-1:0] expected_q [$];
    int mismatches;

    function new();
      mode = MODE_LINEAR;
      mismatches = 0;
      for (int m = 0; m < 8; m++)
        for (int k = 0; k < 6; k++)
          for (int t = 0; t < 6; t++)
            weight[m][k][t] = 0;
      weight[0][0][2] = qw(1, 1);
      weight[1][0][2] = qw(1, 1);
      set_row(1, 1, 0, 0, qw(-1, 1), qw(1, 1), 0, 0);
      set_row(2, 0, 0, 0, qw(1, 1), 0, 0, 0);
      set_row(2, 1, 0, qw(-1, 2), 0, qw(1, 2), 0, 0);
      set_row(2, 2, 0, qw(1, 1), qw(-5, 2), qw(2, 1), qw(-1, 2), 0);
      set_row(2, 3, 0, qw(-1, 2), qw(3, 2), qw(-3, 2), qw(1, 2), 0);
      set_row(3, 0, 0, qw(-1, 16), qw(9, 16), qw(9, 16), qw(-1, 16), 0);
      set_row(3, 1, 0, qw(3, 16), qw(-25, 16), qw(25, 16), qw(-3, 16), 0);
      set_row(3, 2, 0, qw(1, 4), qw(-1, 4), qw(-1, 4), qw(1, 4), 0);
      set_row(3, 3, 0, qw(-1, 1), qw(3, 1), qw(-3, 1), qw(1, 1), 0);
      set_row(3, 5, 0, qw(1, 1), qw(-3, 1), qw(3, 1), qw(-1, 1), 0);
      set_row(4, 0, 0, qw(1, 6), qw(2, 3), qw(1, 6), 0, 0);
      set_row(4, 1, 0, qw(-1, 2), 0, qw(1, 2), 0, 0);
      set_row(4, 2, 0, qw(1, 2), qw(-1, 1), qw(1, 2), 0, 0);
      set_row(4, 3, 0, qw(-1, 6), qw(1, 2), qw(-1, 2), qw(1, 6), 0);
      set_row(5, 0, qw(1, 120), qw(13, 60), qw(11, 20), qw(13, 60), qw(1, 120), 0);
      set_row(5, 1, qw(-1, 24), qw(-5, 12), 0, qw(5, 12), qw(1, 24), 0);
      set_row(5, 2, qw(1, 12), qw(1, 6), qw(-1, 2), qw(1, 6), qw(1, 12), 0);
      set_row(5, 3, qw(-1, 12), qw(1, 6), 0, qw(-1, 6), qw(1, 12), 0);
      set_row(5, 4, qw(1, 24), qw(-1, 6), qw(1, 4), qw(-1, 6), qw(1, 24), 0);
      set_row(5, 5, qw(-1, 120), qw(1, 24), qw(-1, 12), qw(1, 12), qw(-1, 24), qw(1, 120));
      set_row(6, 0, 0, 730509, 7658114, 7658114, 730509, 0);
      set_row(6, 1, 0, -2967321, -7924999, 7924999, 2967321, 0);
      set_row(6, 2, 0, 4256702, -4255957, -4255957, 4256702, 0);
      set_row(6, 3, 0, -2005375, 6361432, -6361432, 2005375, 0);
      set_row(6, 4, 0, -719599, 713395, 713395, -719599, 0);
      set_row(7, 0, 39394, 1552194, 6797020, 6797020, 1552194, 39394);
      set_row(7, 1, -219663, -3641206, -4755134, 4755134, 3641206, 219663);
      set_row(7, 2, 494260, 2715870, -3210114, -3210114, 2715870, 494260);
      set_row(7, 3, -570303, 25929, 2763480, -2763480, -25929, 570303);
      set_row(7, 4, 313189, -958472, 645218, 645218, -958472, 313189);
      set_row(7, 5, -25530, 302462, -724432, 724432, -302462, 25530);
    endfunction

    // rational weight scaled by 2^24, rounded half away from zero
    function int qw(longint n, longint d);
      return int'((n * 2 * 64'sd16777216 + (n < 0 ? -d : d)) / (2 * d));
    endfunction

    function void set_row(int m, int k, int a, int b, int c, int d, int e, int f);
      weight[m][k] = '{a, b, c, d, e, f};
    endfunction

    function longint clip(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function logic signed [SW-1:0] interpolate(interp_item_t it);
      longint c [6];
      longint acc, v, h, y;
      int m;
      m = int'(mode);
      v = longint'(it.phase);
      if (mode inside {MODE_OSC, MODE_OPT4, MODE_OPT6})
        v = v - (64'sd1 <<< (PW - 1));
      for (int k = 0; k < 6; k++) begin
        acc = 0;
        for (int t = 0; t < 6; t++)
          acc += longint'(weight[m][k][t]) * longint'(it.tap[t]);
        acc = (acc + (64'sd1 <<< 15)) >>> 16;
        c[k] = clip(acc, -COEF_LIM, COEF_LIM);
      end
      h = c[5];
      for (int k = 4; k >= 0; k--) begin
        h = ((h * v + (64'sd1 <<< (PW - 1))) >>> PW) + c[k];
        h = clip(h, -COEF_LIM, COEF_LIM);
      end
      y = (h + 128) >>> 8;
      y = clip(y, -SMAX - 1, SMAX);
      return y[SW-1:0];
    endfunction

    function void note_input(interp_item_t it);
      expected_q.push_back(interpolate(it));
    endfunction

    function void check_result(logic signed [SW-1:0] got);
      logic signed [SW-1:0] exp_val;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", got);
        return;
      end
      exp_val = expected_q.pop_front();
      if (got !== exp_val) begin
        mismatches++;
        if (mismatches <= 10)
          $display("interp_out mismatch: expected %0d actual %0d", exp_val, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [MODE_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [PW-1:0] frac_phase_i = '0;
  logic signed [SW-1:0] sample_m2_i = '0, sample_m1_i = '0, sample_0_i = '0;
  logic signed [SW-1:0] sample_p1_i = '0, sample_p2_i = '0, sample_p3_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [SW-1:0] interp_out_o;

  interp_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  polynomial_resampling_interpolator DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .frac_phase_i, .sample_m2_i, .sample_m1_i, .sample_0_i, .sample_p1_i,
    .sample_p2_i, .sample_p3_i, .out_valid_o, .out_ready_i, .interp_out_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

  // receiver: random stalls, plus a single long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i = 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready_i = 1'b0;
      hold_cycles--;
    end else begin
      out_ready_i = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(negedge clk_i) begin
    logic signed [SW-1:0] got;
    #1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = interp_out_o;
      @(posedge clk_i);
      sb.check_result(got);
    end
  end

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(7))
      0: return 24'sh7fffff;
      1: return 24'sh800000;
      2: return SW'($urandom_range(2000)) - 24'sd1000;
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic interp_item_t rand_item();
    interp_item_t it;
    case ($urandom_range(5))
      0: it.phase = '0;
      1: it.phase = '1;
      2: it.phase = 16'h8000;
      default: it.phase = PW'($urandom);
    endcase
    for (int t = 0; t < 6; t++) it.tap[t] = rand_sample();
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_item(interp_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    frac_phase_i = it.phase;
    sample_m2_i = it.tap[0];
    sample_m1_i = it.tap[1];
    sample_0_i = it.tap[2];
    sample_p1_i = it.tap[3];
    sample_p2_i = it.tap[4];
    sample_p3_i = it.tap[5];
    in_valid_i = 1'b1;
    forever begin
      #1;
      if (in_ready_o) begin
        @(posedge clk_i);
        sb.note_input(it);
        @(negedge clk_i);
        break;
      end
      @(negedge clk_i);
    end
  endtask

  task automatic drain_and_set_mode(interp_mode_e m);
    in_valid_i = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = m;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.mode = m;
  endtask

  initial begin
    interp_item_t it;
    int waited;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes first under the reset mode, then under each mode but MODE_OPT6
    for (int m = 0; m < 8; m++) begin
      if (m != 0) drain_and_set_mode(interp_mode_e'(m - 1));
      for (int k = 0; k < 3; k++) begin
        it.phase = (k == 0) ? '1 : ((k == 1) ? '0 : 16'h8000);
        for (int t = 0; t < 6; t++)
          it.tap[t] = (k == 2) ? ((t % 2) ? 24'sh7fffff : 24'sh800000)
                               : ((k == 0) ? 24'sh7fffff : 24'sh800000);
        send_item(it);
      end
    end
    drain_and_set_mode(MODE_OPT6);
    send_item(rand_item());

    for (int p = 0; p < 16; p++) begin
      drain_and_set_mode(p < 8 ? interp_mode_e'(p) : interp_mode_e'($urandom_range(7)));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      if (p == 4) hold_cycles = 300;
      for (int i = 0; i < 114; i++) send_item(rand_item());
    end

    in_valid_i = 1'b0;
    waited = 0;
    while (sb.expected_q.size() != 0 && waited < 100000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (20) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
